[src/dirichlet_boundary_filter_core_macros.svh]
// Assertion macros for the dirichlet boundary filter checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DIRICHLET_BOUNDARY_FILTER_CORE_MACROS_SVH
`define DIRICHLET_BOUNDARY_FILTER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is low.
`define DBF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is low.
`define DBF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks reset behavior.
`define DBF_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dbf_pkg.sv]
// Package for the dirichlet boundary filter: request codes, queue entry type,
// back-end states and shared constants. No dependencies.
`timescale 1ns / 1ps

package dbf_pkg;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_DIM          = 3;
  localparam int QUEUE_DEPTH      = 4;

  localparam int IDX_W = 12;
  localparam int VAL_W = 64;
  localparam int VC_W  = 11;

  localparam logic [VAL_W-1:0] ONE_PATTERN = 64'h3FF0_0000_0000_0000;

  typedef enum logic [2:0] {
    REQ_MARK  = 3'd0,
    REQ_FREE  = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_COEF  = 3'd3,
    REQ_VEC   = 3'd4,
    REQ_DIAG  = 3'd5
  } req_e_t;

  typedef enum logic [2:0] {
    OP_MARK,
    OP_FREE,
    OP_CLEAR,
    OP_COEF,
    OP_VEC,
    OP_DIAG
  } op_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_RUN,
    BK_CLEAR
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             row_ok;
    logic             col_ok;
    logic [VAL_W-1:0] value;
    logic             zero_fill;
  } qentry_t;

endpackage

[src/dirichlet_boundary_filter_core.sv]
// Top level of the dirichlet boundary filter: front end, operation queue
// and back end. Depends on dbf_pkg, dbf_front, dbf_queue and dbf_back.
//
// Usage:
//   Request beats enter on in_valid/in_ready; result beats leave on
//   out_valid/out_ready. cfg_we with cfg_vertex_count sets the number of
//   active vertices; write it only while the block is idle.
//   Mark, free, free-all and unused request codes give no result beat.
//   Throughput: one request per cycle for mark, free, coefficient, vector
//   and diagonal requests outside clearing sweeps while result beats are
//   taken, limited by the single write port and the registered read of the
//   mark/value memories. Free all runs a clearing sweep over all
//   MAX_VERTICES*DIM entries (3072 by default) in the back end; the front
//   keeps filling the queue meanwhile. A request beat passes the queue,
//   the registered memory read and then the result register before
//   out_valid rises. Reset: after rst_n the same sweep clears the table;
//   in_ready stays low until it ends. vertex_count resets to zero.
//   Receiver stall: the result register holds its beat; the lookup stage
//   and the queue back up, then in_ready drops.
`timescale 1ns / 1ps

module dirichlet_boundary_filter_core import dbf_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int DIM          = DEF_DIM,
  parameter int Q_DEPTH      = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [VC_W-1:0]  cfg_vertex_count,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_req_type,
  input  logic [9:0]       in_vertex_index,
  input  logic [1:0]       in_dof_slot,
  input  logic [IDX_W-1:0] in_row_index,
  input  logic [IDX_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_entry_value,
  input  logic             in_zero_fill,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [IDX_W-1:0] out_row,
  output logic [IDX_W-1:0] out_col,
  output logic [VAL_W-1:0] out_value
);

  logic    init_busy, q_full, q_push, q_pop, q_empty;
  qentry_t q_in, q_out;

  dbf_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .DIM          (DIM)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_vertex_count (cfg_vertex_count),
    .init_busy        (init_busy),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_vertex_index  (in_vertex_index),
    .in_dof_slot      (in_dof_slot),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_entry_value   (in_entry_value),
    .in_zero_fill     (in_zero_fill),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  dbf_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  dbf_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .DIM          (DIM)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value)
  );

endmodule

[src/dbf_front.sv]
// Front end: accepts request beats, range-checks indexes against the active
// vertex count and pushes classified operations. Depends on dbf_pkg.
`timescale 1ns / 1ps

module dbf_front import dbf_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int DIM          = DEF_DIM
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [VC_W-1:0]  cfg_vertex_count,
  input  logic             init_busy,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_req_type,
  input  logic [9:0]       in_vertex_index,
  input  logic [1:0]       in_dof_slot,
  input  logic [IDX_W-1:0] in_row_index,
  input  logic [IDX_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_entry_value,
  input  logic             in_zero_fill,
  input  logic             q_full,
  output logic             q_push,
  output qentry_t          q_data
);

  localparam int VW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (VW > VC_W) ? VW : VC_W;
  localparam int LW  = $clog2(MAX_VERTICES * DIM + 1);
  localparam int LXW = (LW > IDX_W) ? LW : IDX_W;

  logic [LW-1:0]    flat_limit_r, flat_limit_nxt;
  logic [CW-1:0]    vc_x, capped;
  logic [IDX_W-1:0] k;
  logic             mark_ok, row_ok, col_ok, keep, accept;

  assign in_ready = !q_full && !init_busy;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && keep;

  always_comb begin
    vc_x   = CW'(cfg_vertex_count);
    capped = (vc_x > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_x;
    flat_limit_nxt = flat_limit_r;
    if (cfg_we) begin
      flat_limit_nxt = LW'(LW'(capped) * LW'(DIM));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flat_limit_r <= '0;
    end else begin
      flat_limit_r <= flat_limit_nxt;
    end
  end

  always_comb begin
    k       = IDX_W'(IDX_W'(in_vertex_index) * IDX_W'(DIM) + IDX_W'(in_dof_slot));
    mark_ok = (in_dof_slot < 2'(DIM)) && (LXW'(k) < LXW'(flat_limit_r));
    row_ok  = LXW'(in_row_index) < LXW'(flat_limit_r);
    col_ok  = LXW'(in_col_index) < LXW'(flat_limit_r);
    q_data.op        = OP_COEF;
    q_data.row       = in_row_index;
    q_data.col       = in_col_index;
    q_data.row_ok    = row_ok;
    q_data.col_ok    = col_ok;
    q_data.value     = in_entry_value;
    q_data.zero_fill = in_zero_fill;
    keep = 1'b0;
    case (req_e_t'(in_req_type))
      REQ_MARK: begin
        q_data.op  = OP_MARK;
        q_data.row = k;
        keep       = mark_ok;
      end
      REQ_FREE: begin
        q_data.op  = OP_FREE;
        q_data.row = k;
        keep       = mark_ok;
      end
      REQ_CLEAR: begin
        q_data.op = OP_CLEAR;
        keep      = 1'b1;
      end
      REQ_COEF: begin
        q_data.op = OP_COEF;
        keep      = 1'b1;
      end
      REQ_VEC: begin
        q_data.op = OP_VEC;
        keep      = 1'b1;
      end
      REQ_DIAG: begin
        q_data.op = OP_DIAG;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

[src/dbf_queue.sv]
// Short FIFO of classified operations between front and back ends.
// Depends on dbf_pkg for the entry type.
`timescale 1ns / 1ps

module dbf_queue import dbf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  input  logic    pop,
  output qentry_t pop_data,
  output logic    empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  qentry_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/dbf_back.sv]
// Back end: owns the mark and value memories, runs the clearing sweep,
// does table lookups and drives the result register. Depends on dbf_pkg.
`timescale 1ns / 1ps

module dbf_back import dbf_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int DIM          = DEF_DIM
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  qentry_t          q_data,
  output logic             q_pop,
  output logic             init_busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [IDX_W-1:0] out_row,
  output logic [IDX_W-1:0] out_col,
  output logic [VAL_W-1:0] out_value
);

  localparam int DEPTH = MAX_VERTICES * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

  logic             mark_mem [DEPTH];
  logic [VAL_W-1:0] val_mem  [DEPTH];

  back_state_t      state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;

  logic             we, wmark, rd_en;
  logic [AW-1:0]    waddr, ra, rb;
  logic [VAL_W-1:0] wval;
  logic [XW-1:0]    row_x, col_x;

  logic             mark_a_r, mark_b_r;
  logic [VAL_W-1:0] val_r;
  logic             s2_valid_r, s2_valid_nxt;
  qentry_t          s2_r;
  logic             s2_fire, s2_free;

  logic             fa, fb, res;
  logic             res_kind;
  logic [IDX_W-1:0] res_col;
  logic [VAL_W-1:0] res_value;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r;
  logic [IDX_W-1:0] out_row_r, out_col_r;
  logic [VAL_W-1:0] out_value_r;

  assign init_busy = (state_r == BK_INIT);
  assign s2_fire   = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_free   = !s2_valid_r || s2_fire;

  assign row_x = XW'(q_data.row);
  assign col_x = XW'(q_data.col);
  assign ra    = row_x[AW-1:0];
  assign rb    = col_x[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    q_pop       = 1'b0;
    we          = 1'b0;
    waddr       = ra;
    wmark       = 1'b0;
    wval        = '0;
    rd_en       = 1'b0;
    case (state_r)
      BK_INIT, BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = BK_RUN;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      BK_RUN: begin
        q_pop = !q_empty && s2_free;
        if (q_pop) begin
          case (q_data.op)
            OP_MARK: begin
              we    = 1'b1;
              wmark = 1'b1;
              wval  = q_data.value;
            end
            OP_FREE: begin
              we = 1'b1;
            end
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = BK_CLEAR;
            end
            OP_COEF, OP_VEC, OP_DIAG: begin
              rd_en = 1'b1;
            end
            default: begin
              rd_en = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = BK_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_INIT;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mark_mem[waddr] <= wmark;
    end
    if (rd_en) begin
      mark_a_r <= mark_mem[ra];
      mark_b_r <= mark_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[waddr] <= wval;
    end
    if (rd_en) begin
      val_r <= val_mem[ra];
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_free) begin
      s2_valid_nxt = rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2_r <= q_data;
    end
  end

  always_comb begin
    fa        = s2_r.row_ok && mark_a_r;
    fb        = s2_r.col_ok && mark_b_r;
    res       = 1'b0;
    res_kind  = 1'b0;
    res_col   = s2_r.col;
    res_value = s2_r.value;
    case (s2_r.op)
      OP_COEF: begin
        res = !(fa || fb);
      end
      OP_VEC: begin
        res      = 1'b1;
        res_kind = 1'b1;
        res_col  = '0;
        if (fa) begin
          res_value = s2_r.zero_fill ? '0 : val_r;
        end
      end
      OP_DIAG: begin
        res       = fa;
        res_col   = s2_r.row;
        res_value = ONE_PATTERN;
      end
      default: begin
        res = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_fire && res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && res) begin
      out_kind_r  <= res_kind;
      out_row_r   <= s2_r.row;
      out_col_r   <= res_col;
      out_value_r <= res_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;

endmodule

[src/dbf_checker.sv]
// Port-level checker for dirichlet_boundary_filter_core, bound to the top.
// Depends on dbf_pkg and dirichlet_boundary_filter_core_macros.svh.
`timescale 1ns / 1ps
`include "dirichlet_boundary_filter_core_macros.svh"

module dbf_checker import dbf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_kind,
  input logic [IDX_W-1:0] out_row,
  input logic [IDX_W-1:0] out_col,
  input logic [VAL_W-1:0] out_value
);

  // stalled result beat must hold
  `DBF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_row) && $stable(out_col) && $stable(out_kind), "result beat changed while stalled")

  // vector element beats carry column zero
  `DBF_ASSERT_IMP(a_vec_col, out_valid && out_kind, out_col == '0, "vector beat with nonzero column")

  // table sweep after reset: no intake and no result
  `DBF_ASSERT_RST(a_rst_quiet, !rst_n, !in_ready && !out_valid, "block active right after reset")

endmodule

bind dirichlet_boundary_filter_core dbf_checker u_chk (.*);
